>>> rtl/core/command_lifecycle_table_defines.svh
// assertion macros used by the checker file
`ifndef COMMAND_LIFECYCLE_TABLE_DEFINES_SVH
`define COMMAND_LIFECYCLE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CLT_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/clt_pkg.sv
`default_nettype none
package clt_pkg;

	// table geometry and register defaults
	localparam int DEF_MAX_SLOTS = 16;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic [2:0] MODE_ADMIT   = 3'd0;
	localparam logic [2:0] MODE_CANCEL  = 3'd1;
	localparam logic [2:0] MODE_BEGIN   = 3'd2;
	localparam logic [2:0] MODE_REQUEUE = 3'd3;
	localparam logic [2:0] MODE_DISCARD = 3'd4;

	// result codes
	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_ALREADY   = 3'd1;
	localparam logic [2:0] RC_NOSPACE   = 3'd2;
	localparam logic [2:0] RC_NOTFOUND  = 3'd3;
	localparam logic [2:0] RC_BUSY      = 3'd4;
	localparam logic [2:0] RC_CANCELLED = 3'd5;

	// lifecycle codes of a slot
	localparam logic [1:0] SL_EMPTY       = 2'd0;
	localparam logic [1:0] SL_QUEUED      = 2'd1;
	localparam logic [1:0] SL_DISPATCHING = 2'd2;
	localparam logic [1:0] SL_CANCELLED   = 2'd3;

	// 120-bit command identity
	typedef struct packed {
		logic [7:0]  msg_kind;
		logic [7:0]  src_id;
		logic [7:0]  dst_id;
		logic [15:0] sess_num;
		logic [15:0] seq;
		logic [31:0] admit_num;
		logic [31:0] cmd_num;
	} ident_t;

endpackage
`default_nettype wire

>>> rtl/core/command_lifecycle_table.sv
// command lifecycle table
// command channel: drive start with mode and the seven identity fields; the
// beat is taken at a clock edge where start is high and busy is low. busy
// stays high until the result beat is on the outputs.
// result channel: result_valid is high for exactly one cycle with status,
// dispatch_execute and remove_request; the receiver cannot stall it, and a
// new command may be started in that same cycle.
// config channel: cfg_data (capacity_in_use) is written when cfg_valid and
// cfg_ready are both high; cfg_ready is high whenever the block is idle.
// timing: slots are read one per cycle from the identity memory and the
// state memory; the scan stops at the first matching slot or after the
// last slot below the capacity (capped at the table size). an unknown mode
// or a zero capacity skips the scan and goes straight to the result. one
// command at a time; the next one can start in the result cycle.
// reset: all slots read as empty (occupancy flags cleared at once), capacity
// returns to 16; no clearing pass is needed.
`default_nettype none
module command_lifecycle_table
	import clt_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [2:0]       mode,
	input  wire logic [7:0]       msg_kind,
	input  wire logic [7:0]       src_id,
	input  wire logic [7:0]       dst_id,
	input  wire logic [15:0]      sess_num,
	input  wire logic [15:0]      seq,
	input  wire logic [31:0]      admit_num,
	input  wire logic [31:0]      cmd_num,
	output logic                  result_valid,
	output logic [2:0]            status,
	output logic                  dispatch_execute,
	output logic                  remove_request,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [1:0] FSM_IDLE   = 2'd0;
	localparam logic [1:0] FSM_SCAN   = 2'd1;
	localparam logic [1:0] FSM_FINISH = 2'd2;

	logic [1:0]           fsm_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     lim_q;
	logic [CNT_W-1:0]     issue_q;
	logic [2:0]           mode_q;
	ident_t               key_q;
	logic [MAX_SLOTS-1:0] occ_q;
	logic                 found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [1:0]           match_st_q;
	logic                 have_empty_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	ident_t               id_rd_s1;
	logic [1:0]           st_rd_s1;
	ident_t               id_mem_q [MAX_SLOTS];
	logic [1:0]           st_mem_q [MAX_SLOTS];

	ident_t               key_in;
	logic [LIM_W-1:0]     cap_ext;
	logic [LIM_W-1:0]     lim_sat;
	logic [CNT_W-1:0]     lim_in;
	logic                 accept;
	logic                 issue_en;
	logic [IDX_W-1:0]     rd_idx;
	logic                 cmp_hit;
	logic                 cmp_last;
	logic                 scan_done;
	logic [2:0]           res_status;
	logic                 res_exec;
	logic                 res_remove;
	logic                 id_we;
	logic                 st_we;
	logic [1:0]           st_wdata;
	logic [IDX_W-1:0]     wr_idx;
	logic                 occ_set;
	logic                 occ_clr;

	// handshakes
	assign busy      = (fsm_q != FSM_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	// identity of the incoming beat
	always_comb begin
		key_in.msg_kind  = msg_kind;
		key_in.src_id    = src_id;
		key_in.dst_id    = dst_id;
		key_in.sess_num  = sess_num;
		key_in.seq       = seq;
		key_in.admit_num = admit_num;
		key_in.cmd_num   = cmd_num;
	end

	// effective capacity, saturated to the table size
	assign cap_ext = LIM_W'(cap_q);
	assign lim_sat = (cap_ext > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS) : cap_ext;
	assign lim_in  = lim_sat[CNT_W-1:0];

	// scan address and compare stage
	assign issue_en  = (fsm_q == FSM_SCAN) && (issue_q < lim_q);
	assign rd_idx    = issue_q[IDX_W-1:0];
	assign cmp_hit   = cmp_vld_s1 && occ_q[cmp_idx_s1] && (id_rd_s1 == key_q);
	assign cmp_last  = (CNT_W'(cmp_idx_s1) + CNT_W'(1)) == lim_q;
	assign scan_done = cmp_hit || (cmp_vld_s1 && cmp_last);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// command payload latched on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= key_in;
			lim_q  <= lim_in;
		end
	end

	// identity and state memories, one read and one write port each
	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem_q[wr_idx] <= key_q;
		end
		if (st_we) begin
			st_mem_q[wr_idx] <= st_wdata;
		end
		id_rd_s1 <= id_mem_q[rd_idx];
		st_rd_s1 <= st_mem_q[rd_idx];
	end

	// sequencer: scan slots (no scan for an unknown mode or zero capacity), then write back and report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q        <= FSM_IDLE;
			issue_q      <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			found_q      <= 1'b0;
			match_idx_q  <= '0;
			match_st_q   <= SL_EMPTY;
			have_empty_q <= 1'b0;
			empty_idx_q  <= '0;
		end else begin
			case (fsm_q)
				FSM_IDLE: begin
					if (accept) begin
						issue_q      <= '0;
						cmp_vld_s1   <= 1'b0;
						found_q      <= 1'b0;
						have_empty_q <= 1'b0;
						if ((mode > MODE_DISCARD) || (lim_in == '0)) begin
							fsm_q <= FSM_FINISH;
						end else begin
							fsm_q <= FSM_SCAN;
						end
					end
				end
				FSM_SCAN: begin
					if (issue_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					cmp_vld_s1 <= issue_en && !scan_done;
					cmp_idx_s1 <= rd_idx;
					if (cmp_vld_s1 && !occ_q[cmp_idx_s1] && !have_empty_q) begin
						have_empty_q <= 1'b1;
						empty_idx_q  <= cmp_idx_s1;
					end
					if (cmp_hit) begin
						found_q     <= 1'b1;
						match_idx_q <= cmp_idx_s1;
						match_st_q  <= st_rd_s1;
					end
					if (scan_done) begin
						fsm_q <= FSM_FINISH;
					end
				end
				FSM_FINISH: begin
					fsm_q <= FSM_IDLE;
				end
				default: begin
					fsm_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// operation decode on the found slot, or on the first empty slot for an admit
	always_comb begin
		res_status = RC_OK;
		res_exec   = 1'b0;
		res_remove = 1'b0;
		id_we      = 1'b0;
		st_we      = 1'b0;
		st_wdata   = SL_QUEUED;
		wr_idx     = match_idx_q;
		occ_set    = 1'b0;
		occ_clr    = 1'b0;
		case (mode_q)
			MODE_ADMIT: begin
				if (found_q) begin
					res_status = RC_ALREADY;
				end else if (have_empty_q) begin
					id_we   = 1'b1;
					st_we   = 1'b1;
					wr_idx  = empty_idx_q;
					occ_set = 1'b1;
				end else begin
					res_status = RC_NOSPACE;
				end
			end
			MODE_CANCEL: begin
				if (!found_q) begin
					res_status = RC_NOTFOUND;
				end else begin
					st_we      = 1'b1;
					st_wdata   = SL_CANCELLED;
					res_remove = 1'b1;
				end
			end
			MODE_BEGIN: begin
				if (!found_q) begin
					res_status = RC_NOTFOUND;
				end else if (match_st_q == SL_CANCELLED) begin
					occ_clr = 1'b1;
				end else if (match_st_q == SL_QUEUED) begin
					st_we    = 1'b1;
					st_wdata = SL_DISPATCHING;
					res_exec = 1'b1;
				end else begin
					res_status = RC_BUSY;
				end
			end
			MODE_REQUEUE: begin
				if (!found_q) begin
					res_status = RC_NOTFOUND;
				end else if (match_st_q == SL_CANCELLED) begin
					res_status = RC_CANCELLED;
				end else if (match_st_q == SL_DISPATCHING) begin
					st_we    = 1'b1;
					st_wdata = SL_QUEUED;
				end else begin
					res_status = RC_BUSY;
				end
			end
			MODE_DISCARD: begin
				if (!found_q) begin
					res_status = RC_NOTFOUND;
				end else begin
					occ_clr = 1'b1;
				end
			end
			default: begin
				res_status = RC_BUSY;
			end
		endcase
		if (fsm_q != FSM_FINISH) begin
			id_we   = 1'b0;
			st_we   = 1'b0;
			occ_set = 1'b0;
			occ_clr = 1'b0;
		end
	end

	// occupancy flags: a clear flag reads as an empty slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (occ_set) begin
			occ_q[wr_idx] <= 1'b1;
		end else if (occ_clr) begin
			occ_q[wr_idx] <= 1'b0;
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (fsm_q == FSM_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (fsm_q == FSM_FINISH) begin
			status           <= res_status;
			dispatch_execute <= res_exec;
			remove_request   <= res_remove;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/clt_checker.sv
`default_nettype none
`include "command_lifecycle_table_defines.svh"
module clt_checker
	import clt_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [2:0] status,
	input wire logic       dispatch_execute,
	input wire logic       remove_request
);

	// an accepted command holds off the next one
	`CLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")

	// a result beat closes a busy period
	`CLT_ASSERT(a_result_after_busy, result_valid, $past(busy) && !busy, "result beat outside a command")

	// result codes stay in range
	`CLT_ASSERT(a_status_range, result_valid, status <= RC_CANCELLED, "status code out of range")

	// execute and remove flags only with a good status and never together
	`CLT_ASSERT(a_flags_ok, result_valid && (dispatch_execute || remove_request), (status == RC_OK) && !(dispatch_execute && remove_request), "flag with bad status")

endmodule

bind command_lifecycle_table clt_checker u_clt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.result_valid     (result_valid),
	.status           (status),
	.dispatch_execute (dispatch_execute),
	.remove_request   (remove_request)
);
`default_nettype wire

>>> dv/tb_command_lifecycle_table.sv
`timescale 1ns / 100ps

module tb_command_lifecycle_table
	import clt_pkg::*;
;

	typedef struct packed {
		logic [2:0] status;
		logic       execute;
		logic       remove;
	} outcome_t;

	// slot table mirror: works out the outcome of every accepted command beat
	class clt_scoreboard;
		logic [1:0]       slot_phase[DEF_MAX_SLOTS];
		ident_t           slot_key[DEF_MAX_SLOTS];
		logic [CAP_W-1:0] capacity;
		outcome_t         due_outcomes[$];
		int               errors;
		int               commands;
		int               results;
		int               status_seen[8];

		function new();
			foreach (slot_phase[i]) slot_phase[i] = SL_EMPTY;
			capacity = CAP_RESET;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		function void note_command(logic [2:0] op, ident_t key);
			outcome_t o;
			int       live;
			int       hit;
			o = '{status: RC_OK, execute: 1'b0, remove: 1'b0};
			live = (capacity > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : int'(capacity);
			hit = -1;
			commands++;
			if (op > MODE_DISCARD) begin
				o.status = RC_BUSY;
			end else begin
				// lowest occupied slot below the capacity with the same identity
				for (int i = 0; i < live; i++) begin
					if (hit < 0 && slot_phase[i] != SL_EMPTY && slot_key[i] == key) hit = i;
				end
				if (op == MODE_ADMIT) begin
					if (hit >= 0) begin
						o.status = RC_ALREADY;
					end else begin
						o.status = RC_NOSPACE;
						for (int i = 0; i < live; i++) begin
							if (o.status == RC_NOSPACE && slot_phase[i] == SL_EMPTY) begin
								slot_key[i] = key;
								slot_phase[i] = SL_QUEUED;
								o.status = RC_OK;
							end
						end
					end
				end else if (hit < 0) begin
					o.status = RC_NOTFOUND;
				end else begin
					case (op)
						MODE_CANCEL: begin
							slot_phase[hit] = SL_CANCELLED;
							o.remove = 1'b1;
						end
						MODE_BEGIN: begin
							if (slot_phase[hit] == SL_CANCELLED) begin
								slot_phase[hit] = SL_EMPTY;
							end else if (slot_phase[hit] == SL_QUEUED) begin
								slot_phase[hit] = SL_DISPATCHING;
								o.execute = 1'b1;
							end else begin
								o.status = RC_BUSY;
							end
						end
						MODE_REQUEUE: begin
							if (slot_phase[hit] == SL_CANCELLED) o.status = RC_CANCELLED;
							else if (slot_phase[hit] != SL_DISPATCHING) o.status = RC_BUSY;
							else slot_phase[hit] = SL_QUEUED;
						end
						default: begin
							slot_phase[hit] = SL_EMPTY;
						end
					endcase
				end
			end
			due_outcomes.push_back(o);
		endfunction

		function void check_outcome(logic [2:0] st, logic ex, logic rm);
			outcome_t o;
			results++;
			if (due_outcomes.size() == 0) begin
				$display("%0t: result beat with nothing pending (status %0d)", $time, st);
				errors++;
				return;
			end
			o = due_outcomes.pop_front();
			status_seen[o.status]++;
			if (st !== o.status) begin
				$display("%0t: status expected %0d actual %0d", $time, o.status, st);
				errors++;
			end
			if (ex !== o.execute) begin
				$display("%0t: dispatch_execute expected %0b actual %0b", $time, o.execute, ex);
				errors++;
			end
			if (rm !== o.remove) begin
				$display("%0t: remove_request expected %0b actual %0b", $time, o.remove, rm);
				errors++;
			end
		endfunction

		function void close_out();
			if (due_outcomes.size() != 0) begin
				$display("%0t: %0d results never arrived", $time, due_outcomes.size());
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [2:0]       mode;
	logic [7:0]       msg_kind;
	logic [7:0]       src_id;
	logic [7:0]       dst_id;
	logic [15:0]      sess_num;
	logic [15:0]      seq;
	logic [31:0]      admit_num;
	logic [31:0]      cmd_num;
	logic             result_valid;
	logic [2:0]       status;
	logic             dispatch_execute;
	logic             remove_request;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	clt_scoreboard sb = new();
	int            idle_pct;
	ident_t        known_keys[20];

	command_lifecycle_table DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.msg_kind         (msg_kind),
		.src_id           (src_id),
		.dst_id           (dst_id),
		.sess_num         (sess_num),
		.seq              (seq),
		.admit_num        (admit_num),
		.cmd_num          (cmd_num),
		.result_valid     (result_valid),
		.status           (status),
		.dispatch_execute (dispatch_execute),
		.remove_request   (remove_request),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watch every beat at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) sb.check_outcome(status, dispatch_execute, remove_request);
			if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
			if (start && !busy) begin
				sb.note_command(mode, {msg_kind, src_id, dst_id, sess_num, seq,
					admit_num, cmd_num});
			end
		end
	end

	function automatic ident_t random_key();
		ident_t k;
		k = 120'({$urandom(), $urandom(), $urandom(), $urandom()});
		return k;
	endfunction

	// hold a command beat until it is taken, then maybe leave a gap
	task automatic send_cmd(logic [2:0] op, ident_t key);
		start <= 1'b1;
		mode <= op;
		msg_kind <= key.msg_kind;
		src_id <= key.src_id;
		dst_id <= key.dst_id;
		sess_num <= key.sess_num;
		seq <= key.seq;
		admit_num <= key.admit_num;
		cmd_num <= key.cmd_num;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 22)) @(negedge clk);
		end
	endtask

	// stop issuing and let every outstanding result come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.due_outcomes.size() != 0 || busy);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly commands on a small set of live identities, some near misses and noise
	task automatic random_burst(int count);
		int         pick;
		logic [2:0] op;
		ident_t     key;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 30) op = MODE_ADMIT;
			else if (pick < 42) op = MODE_CANCEL;
			else if (pick < 64) op = MODE_BEGIN;
			else if (pick < 82) op = MODE_REQUEUE;
			else if (pick < 94) op = MODE_DISCARD;
			else op = 3'($urandom_range(5, 7));
			pick = $urandom_range(99);
			key = known_keys[$urandom_range(19)];
			if (pick >= 90) key = random_key();
			else if (pick >= 78) key = key ^ (120'd1 << $urandom_range(119));
			send_cmd(op, key);
		end
	endtask

	initial begin
		ident_t           key_a;
		ident_t           key_b;
		ident_t           key_c;
		logic [CAP_W-1:0] caps[6];
		int               pcts[6];
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ADMIT;
		msg_kind = '0;
		src_id = '0;
		dst_id = '0;
		sess_num = '0;
		seq = '0;
		admit_num = '0;
		cmd_num = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		caps = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd1, 5'd16};
		pcts = '{0, 56, 0, 31, 56, 0};
		foreach (known_keys[i]) known_keys[i] = random_key();
		key_a = '0;
		key_b = '1;
		key_c = random_key();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full lifecycle of one command, extremes of the identity fields
		send_cmd(MODE_ADMIT, key_a);
		send_cmd(MODE_ADMIT, key_a);
		send_cmd(MODE_ADMIT, key_b);
		send_cmd(MODE_REQUEUE, key_a);
		send_cmd(MODE_BEGIN, key_a);
		send_cmd(MODE_BEGIN, key_a);
		send_cmd(MODE_REQUEUE, key_a);
		send_cmd(MODE_CANCEL, key_a);
		send_cmd(MODE_REQUEUE, key_a);
		send_cmd(MODE_BEGIN, key_a);
		send_cmd(MODE_BEGIN, key_a);
		send_cmd(MODE_CANCEL, key_b);
		send_cmd(MODE_DISCARD, key_b);
		send_cmd(MODE_DISCARD, key_b);
		// unknown modes leave the table alone
		send_cmd(3'd5, key_b);
		send_cmd(3'd6, key_a);
		send_cmd(3'd7, key_c);
		// one flipped identity bit must miss
		send_cmd(MODE_ADMIT, key_c);
		send_cmd(MODE_BEGIN, key_c ^ (120'd1 << $urandom_range(119)));
		send_cmd(MODE_DISCARD, key_c);
		// zero capacity: nothing searched or allocated
		write_capacity(5'd0);
		send_cmd(MODE_ADMIT, key_a);
		send_cmd(MODE_CANCEL, key_a);
		// single slot fills at once
		write_capacity(5'd1);
		send_cmd(MODE_ADMIT, key_a);
		send_cmd(MODE_ADMIT, key_b);

		// random phases over several capacities, slots kept across changes
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			idle_pct = pcts[p];
			random_burst(92);
		end
		drain();
		repeat (20) @(posedge clk);
		sb.close_out();
		$display("ran %0d commands, %0d results, capacities 0 to 31 including saturation",
			sb.commands, sb.results);
		$display("status mix: ok %0d already %0d nospace %0d notfound %0d busy %0d cancelled %0d",
			sb.status_seen[RC_OK], sb.status_seen[RC_ALREADY], sb.status_seen[RC_NOSPACE],
			sb.status_seen[RC_NOTFOUND], sb.status_seen[RC_BUSY], sb.status_seen[RC_CANCELLED]);
		if (sb.errors == 0) begin
			$display("command_lifecycle_table regression: pass");
		end else begin
			$display("command_lifecycle_table regression: fail");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("%0t: timed out", $time);
		$display("command_lifecycle_table regression: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/clt_pkg.sv
rtl/core/command_lifecycle_table.sv
rtl/core/clt_checker.sv
dv/tb_command_lifecycle_table.sv
